>>> hw/rtl/adip_pkg.sv
// Shared constants and types for the ASCII decimal integer parser.
// No dependencies; imported by adip_parse, ascii_decimal_integer_parser and tb_top.
package adip_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int NARROW_WIDTH    = 16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] value;
    logic [7:0]                  terminator;
    logic                        had_digits;
  } result_t;

endpackage

>>> hw/rtl/ascii_decimal_integer_parser.sv
// Top level of the ASCII decimal integer parser: config register and result register.
// Depends on adip_pkg and adip_parse.
//
// Usage:
//   Input channel (in_valid/in_ready/in_char_code) carries one character per
//   transaction. Leading spaces are skipped, then an optional '-' and an
//   optional '+', then decimal digits. The first character that does not fit
//   ends the number and produces one output transaction (out_value,
//   out_terminator, out_had_digits); other characters produce none.
//   cfg_we/cfg_wdata write narrow_mode (1: result truncated to signed 16 bits).
//   A terminating character passes through the input register, then the result
//   register, before it appears on the output.
//   Throughput: one character per cycle unless a terminator waits behind a held
//   result; the single-pass step logic between the two registers sets this.
//   A stalled receiver holds the result register; the input register still
//   drains characters that produce no result, and in_ready falls only when a
//   terminator waits behind a held result.
//   Reset (rst_n low, synchronous) clears the parser state, both valid flags
//   and narrow_mode.
module ascii_decimal_integer_parser #(
  parameter int VALUE_WIDTH = adip_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_char_code,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [adip_pkg::OUT_WIDTH-1:0] out_value,
  output logic [7:0]                            out_terminator,
  output logic                                  out_had_digits,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata
);
  import adip_pkg::*;

  logic    narrow_mode_r;
  logic    out_valid_r;
  result_t out_r;
  result_t res;
  logic    res_load;
  logic    res_free;

  assign res_free = !out_valid_r || out_ready;

  adip_parse #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_char_code(in_char_code),
    .in_ready    (in_ready),
    .narrow_mode (narrow_mode_r),
    .res_free    (res_free),
    .res_load    (res_load),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_mode_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        narrow_mode_r <= cfg_wdata;
      end
      if (res_free) begin
        out_valid_r <= res_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_r.value;
  assign out_terminator = out_r.terminator;
  assign out_had_digits = out_r.had_digits;

  a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_had_digits |-> out_value == '0)
    else $error("result without digits is not zero");

  a_narrow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && narrow_mode_r |->
      (out_value[OUT_WIDTH-1:NARROW_WIDTH-1] == '0) ||
      (out_value[OUT_WIDTH-1:NARROW_WIDTH-1] == '1))
    else $error("narrow result outside signed 16-bit range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

endmodule

>>> hw/rtl/adip_parse.sv
// Input register, parser state and single-pass next-state and result logic.
// Depends on adip_pkg.
module adip_parse #(
  parameter int VALUE_WIDTH = adip_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_char_code,
  output logic             in_ready,
  input  logic             narrow_mode,
  input  logic             res_free,
  output logic             res_load,
  output adip_pkg::result_t res
);
  import adip_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_MINUS,
    PH_SIGNED,
    PH_DIGITS
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   in_valid_r;
  logic [7:0]             char_r;

  logic                   is_digit;
  logic [3:0]             digit;
  logic [VALUE_WIDTH-1:0] acc_x10_d;
  logic [VALUE_WIDTH-1:0] wrapped;
  logic [OUT_WIDTH-1:0]   full_val;
  logic [OUT_WIDTH-1:0]   sel_val;
  logic                   fin;
  logic                   adv;

  assign is_digit  = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign digit     = 4'(char_r - CH_ZERO);
  assign acc_x10_d = {acc_r[VALUE_WIDTH-4:0], 3'b000} + {acc_r[VALUE_WIDTH-2:0], 1'b0}
                     + VALUE_WIDTH'(digit);
  assign wrapped   = neg_r ? (VALUE_WIDTH'(0) - acc_r) : acc_r;

  generate
    if (VALUE_WIDTH >= OUT_WIDTH) begin : g_trunc
      assign full_val = wrapped[OUT_WIDTH-1:0];
    end else begin : g_sext
      assign full_val = {{(OUT_WIDTH-VALUE_WIDTH){wrapped[VALUE_WIDTH-1]}}, wrapped};
    end
  endgenerate

  assign sel_val = narrow_mode
                   ? {{(OUT_WIDTH-NARROW_WIDTH){full_val[NARROW_WIDTH-1]}},
                      full_val[NARROW_WIDTH-1:0]}
                   : full_val;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    fin       = 1'b0;
    if (is_digit) begin
      acc_nxt   = acc_x10_d;
      phase_nxt = PH_DIGITS;
    end else begin
      unique case (phase_r)
        PH_SKIP: begin
          if (char_r == CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_MINUS;
          end else if (char_r == CH_PLUS) begin
            phase_nxt = PH_SIGNED;
          end else if (char_r != CH_SPACE) begin
            fin = 1'b1;
          end
        end
        PH_MINUS: begin
          if (char_r == CH_PLUS) begin
            phase_nxt = PH_SIGNED;
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end
    if (fin) begin
      phase_nxt = PH_SKIP;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
    end
  end

  assign adv      = in_valid_r && (!fin || res_free);
  assign res_load = in_valid_r && fin && res_free;
  assign in_ready = !in_valid_r || adv;

  assign res.value      = sel_val;
  assign res.terminator = char_r;
  assign res.had_digits = (phase_r == PH_DIGITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SKIP;
      neg_r      <= 1'b0;
      acc_r      <= '0;
      in_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      char_r <= in_char_code;
    end
  end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for ascii_decimal_integer_parser: random and directed character
// streams, a scoreboard class that predicts every parsed number, random stalls on both sides.
// Depends on adip_pkg and the parser RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import adip_pkg::*;

  typedef enum logic [1:0] {
    SKIP_SPACES,
    AFTER_MINUS,
    AFTER_SIGN,
    IN_DIGITS
  } parse_phase_t;

  class number_checker;
    parse_phase_t           phase;
    bit                     negative;
    logic [OUT_WIDTH-1:0]   accumulator;
    bit                     narrow;
    result_t                expected_numbers[$];
    int                     errors;

    function new();
      phase       = SKIP_SPACES;
      negative    = 1'b0;
      accumulator = '0;
      narrow      = 1'b0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction

    function void close_number(logic [7:0] c);
      logic [OUT_WIDTH-1:0] v;
      result_t              r;
      v = negative ? -accumulator : accumulator;
      if (narrow) begin
        v = {{(OUT_WIDTH-NARROW_WIDTH){v[NARROW_WIDTH-1]}}, v[NARROW_WIDTH-1:0]};
      end
      r.value      = v;
      r.terminator = c;
      r.had_digits = (phase == IN_DIGITS);
      expected_numbers.push_back(r);
      phase       = SKIP_SPACES;
      negative    = 1'b0;
      accumulator = '0;
    endfunction

    function void note_char(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) begin
        accumulator = accumulator * 10 + OUT_WIDTH'(c - CH_ZERO);
        phase       = IN_DIGITS;
      end else begin
        case (phase)
          SKIP_SPACES: begin
            if (c == CH_MINUS) begin
              negative = 1'b1;
              phase    = AFTER_MINUS;
            end else if (c == CH_PLUS) begin
              phase = AFTER_SIGN;
            end else if (c != CH_SPACE) begin
              close_number(c);
            end
          end
          AFTER_MINUS: begin
            if (c == CH_PLUS) begin
              phase = AFTER_SIGN;
            end else begin
              close_number(c);
            end
          end
          default: close_number(c);
        endcase
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_number(logic signed [OUT_WIDTH-1:0] value, logic [7:0] terminator,
                      logic had_digits);
      result_t exp_r;
      if (expected_numbers.size() == 0) begin
        report($sformatf("unexpected number %0d term %02h", value, terminator));
      end else begin
        exp_r = expected_numbers.pop_front();
        if (value !== exp_r.value)
          report($sformatf("value %0d, expected %0d", value, exp_r.value));
        if (terminator !== exp_r.terminator)
          report($sformatf("terminator %02h, expected %02h", terminator, exp_r.terminator));
        if (had_digits !== exp_r.had_digits)
          report($sformatf("had_digits %0b, expected %0b", had_digits, exp_r.had_digits));
      end
    endtask
  endclass

  logic                        clk;
  logic                        rst_n          = 1'b0;
  logic                        in_valid       = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_char_code   = 8'h00;
  logic                        out_valid;
  logic                        out_ready      = 1'b0;
  logic signed [OUT_WIDTH-1:0] out_value;
  logic [7:0]                  out_terminator;
  logic                        out_had_digits;
  logic                        cfg_we         = 1'b0;
  logic                        cfg_wdata      = 1'b0;

  number_checker chk = new();
  int            in_idle_pct  = 0;
  int            out_idle_pct = 0;
  int            chars_sent   = 0;

  ascii_decimal_integer_parser u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_terminator (out_terminator),
    .out_had_digits (out_had_digits),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      chk.check_number(out_value, out_terminator, out_had_digits);
    end
  end

  task automatic send_char(logic [7:0] c);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chk.note_char(c);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // hold the input until every number has come out, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_narrow(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    chk.narrow = v;
  endtask

  task automatic send_number();
    int         n_digits;
    int         pick;
    logic [7:0] term;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) send_char(CH_SPACE);
    case ($urandom_range(0, 11))
      4, 5: send_char(CH_MINUS);
      6:    send_char(CH_PLUS);
      7:    send_text("-+");
      8:    send_text("+-");
      9:    send_text("--");
      10:   send_text("-+-");
      11:   send_text("- ");
      default: ;
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) n_digits = 0;
    else if (pick < 4) n_digits = $urandom_range(9, 12);
    else n_digits = $urandom_range(1, 5);
    repeat (n_digits) send_char(8'(CH_ZERO + $urandom_range(0, 9)));
    case ($urandom_range(0, 4))
      0:       term = ",";
      1:       term = 8'h0A;
      2:       term = CH_SPACE;
      default: term = 8'($urandom_range(0, 255));
    endcase
    send_char(term);
  endtask

  task automatic run_segment(int src_idle, int dst_idle, int n_chars);
    int start;
    in_idle_pct  = src_idle;
    out_idle_pct = dst_idle;
    start        = chars_sent;
    while (chars_sent - start < n_chars) begin
      if ($urandom_range(0, 9) == 0) send_char(8'($urandom_range(0, 255)));
      else send_number();
    end
    send_char(";");
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n        <= 1'b1;
    in_idle_pct  = 13;
    out_idle_pct = 64;
    @(posedge clk);

    send_text("  -12,");
    send_text("+-");
    send_text("-+-");
    send_char("9");
    send_char(8'hFF);
    send_text("--");
    send_char("0");
    send_char(8'h00);
    send_text("- 99999");
    send_char(8'h80);

    drain();
    set_narrow(1'b1);
    run_segment(13, 64, 140);
    drain();
    set_narrow(1'b0);
    run_segment(64, 13, 140);
    drain();
    set_narrow(1'b1);
    run_segment(0, 0, 130);

    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (chk.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
